// ----- src/obd_engine_pid_response_parser_top_macros.svh -----
// assertion macros for the pid response parser
`ifndef OBD_ENGINE_PID_RESPONSE_PARSER_TOP_MACROS_SVH
`define OBD_ENGINE_PID_RESPONSE_PARSER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define OBD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define OBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/obdpid_pkg.sv -----
// types, constants and decode functions for the pid response parser
`default_nettype none

package obdpid_pkg;

	typedef enum logic [3:0] {
		PH_SEEK_RPM   = 4'd0,
		PH_RPM_DATA   = 4'd1,
		PH_SEEK_SPEED = 4'd2,
		PH_SPEED_DATA = 4'd3,
		PH_SEEK_LOAD  = 4'd4,
		PH_LOAD_DATA  = 4'd5,
		PH_SEEK_THR   = 4'd6,
		PH_THR_DATA   = 4'd7,
		PH_DONE       = 4'd8,
		PH_FAILED     = 4'd9
	} phase_t;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NO_RPM_ID   = 3'd1;
	localparam logic [2:0] ST_RPM_SHORT   = 3'd2;
	localparam logic [2:0] ST_RPM_BAD     = 3'd3;
	localparam logic [2:0] ST_NO_SPEED    = 3'd4;
	localparam logic [2:0] ST_NO_LOAD     = 3'd5;
	localparam logic [2:0] ST_NO_THROTTLE = 3'd6;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_4     = 8'h34;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_D     = 8'h44;

	// floor(0.621371 * 2^32), km/h to mph
	localparam logic [31:0] KMH_TO_MPH = 32'd2668768123;
	localparam logic [6:0]  PCT_SCALE  = 7'd100;

	typedef struct packed {
		logic       ok;
		logic [7:0] value;
	} hex_pair_t;

	// {valid, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic hex_pair_t hex_pair(input logic [7:0] first, input logic [7:0] second);
		logic [4:0] hi;
		logic [4:0] lo;
		hex_pair_t  r;
		hi = hex_digit(first);
		lo = hex_digit(second);
		r.ok = hi[4];
		if (lo[4]) begin
			r.value = {hi[3:0], lo[3:0]};
		end else begin
			r.value = {4'd0, hi[3:0]};
		end
		return r;
	endfunction

	function automatic logic [15:0] pid_id(input phase_t ph);
		logic [15:0] r;
		unique case (ph)
			PH_SEEK_RPM:   r = {CH_0, CH_C};
			PH_SEEK_SPEED: r = {CH_0, CH_D};
			PH_SEEK_LOAD:  r = {CH_0, CH_4};
			default:       r = {CH_1, CH_1};
		endcase
		return r;
	endfunction

	function automatic logic [2:0] end_status(input phase_t ph);
		logic [2:0] r;
		unique case (ph)
			PH_SEEK_RPM:                  r = ST_NO_RPM_ID;
			PH_RPM_DATA:                  r = ST_RPM_SHORT;
			PH_SEEK_SPEED, PH_SPEED_DATA: r = ST_NO_SPEED;
			PH_SEEK_LOAD, PH_LOAD_DATA:   r = ST_NO_LOAD;
			PH_SEEK_THR, PH_THR_DATA:     r = ST_NO_THROTTLE;
			default:                      r = ST_OK;
		endcase
		return r;
	endfunction

	// floor(b * 100 / 255)
	function automatic logic [6:0] scale_pct(input logic [7:0] b);
		logic [14:0] x;
		logic [15:0] s;
		x = {7'd0, b} * {8'd0, PCT_SCALE};
		s = {1'b0, x} + {9'd0, x[14:8]} + 16'd1;
		return s[14:8];
	endfunction

endpackage

`default_nettype wire

// ----- src/obd_engine_pid_response_parser_top.sv -----
// top level of the obd mode 01 pid response parser
`default_nettype none

// Parses an adapter's ASCII response one character beat at a time and, on the
// beat marked is_last, returns engine rpm, speed in mph, load and throttle in
// percent with a status code (values are zero when status is nonzero). Space,
// CR and LF are skipped. One beat is taken every cycle: a beat is held in
// the input register, is decoded by one pass of logic against the parser
// state, and its result lands in the output register, so out_valid rises
// once the last beat's result is registered there. The input side only
// waits when a last beat finds the output register still full and out_ready low.

`include "obd_engine_pid_response_parser_top_macros.svh"

module obd_engine_pid_response_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_code,
	input  wire logic        is_last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [13:0]      engine_rpm,
	output logic [7:0]       speed_mph,
	output logic [6:0]       load_percent,
	output logic [6:0]       throttle_percent,
	output logic [2:0]       status
);

	logic                  valid_s1;
	logic [7:0]            char_s1;
	logic                  last_s1;
	logic                  out_free;
	logic                  s1_go;
	logic                  feed;

	obdpid_pkg::phase_t    phase_q;
	obdpid_pkg::phase_t    phase_d;
	logic [7:0]            prior_q;
	logic [7:0]            prior_d;
	logic                  prior_valid_q;
	logic                  prior_valid_d;
	logic [23:0]           pend_q;
	logic [23:0]           pend_d;
	logic [1:0]            cnt_q;
	logic [1:0]            cnt_d;
	logic [13:0]           rpm_q;
	logic [13:0]           rpm_d;
	logic [7:0]            speed_q;
	logic [7:0]            speed_d;
	logic [6:0]            load_q;
	logic [6:0]            load_d;
	logic [6:0]            thr_q;
	logic [6:0]            thr_d;
	logic [2:0]            err_q;
	logic [2:0]            err_d;

	logic                  id_match;
	logic [15:0]           id_chars;
	obdpid_pkg::hex_pair_t pair_a;
	obdpid_pkg::hex_pair_t pair_b;
	logic [39:0]           mph_prod;
	logic [2:0]            st_d;

	logic                  out_valid_q;
	logic [13:0]           rpm_out_q;
	logic [7:0]            speed_out_q;
	logic [6:0]            load_out_q;
	logic [6:0]            thr_out_q;
	logic [2:0]            status_out_q;

	logic                  chk_err;
	logic                  chk_zero;
	logic                  chk_range;
	logic                  chk_fresh;

	assign out_free = !out_valid_q || out_ready;
	assign s1_go    = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || s1_go;
	assign feed     = s1_go && char_s1 != obdpid_pkg::CH_SPACE
		&& char_s1 != obdpid_pkg::CH_CR && char_s1 != obdpid_pkg::CH_LF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			last_s1 <= is_last;
		end
	end

	assign id_chars = obdpid_pkg::pid_id(phase_q);
	assign id_match = prior_valid_q && prior_q == id_chars[15:8] && char_s1 == id_chars[7:0];
	assign pair_a   = obdpid_pkg::hex_pair(pend_q[23:16], pend_q[15:8]);
	assign pair_b   = obdpid_pkg::hex_pair(pend_q[7:0], char_s1);
	assign mph_prod = {32'd0, pair_b.value} * {8'd0, obdpid_pkg::KMH_TO_MPH};

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (feed) begin
			unique case (phase_q)
				obdpid_pkg::PH_SEEK_RPM, obdpid_pkg::PH_SEEK_SPEED,
				obdpid_pkg::PH_SEEK_LOAD, obdpid_pkg::PH_SEEK_THR: begin
					if (id_match) begin
						phase_d = obdpid_pkg::phase_t'(phase_q + 4'd1);
					end
				end
				obdpid_pkg::PH_RPM_DATA: begin
					if (cnt_q == 2'd3) begin
						phase_d = (pair_a.ok && pair_b.ok)
							? obdpid_pkg::PH_SEEK_SPEED : obdpid_pkg::PH_FAILED;
					end
				end
				obdpid_pkg::PH_SPEED_DATA, obdpid_pkg::PH_LOAD_DATA,
				obdpid_pkg::PH_THR_DATA: begin
					if (cnt_q == 2'd1) begin
						phase_d = pair_b.ok ? obdpid_pkg::phase_t'(phase_q + 4'd1)
							: obdpid_pkg::PH_FAILED;
					end
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// datapath
	always_comb begin
		prior_d       = prior_q;
		prior_valid_d = prior_valid_q;
		pend_d        = pend_q;
		cnt_d         = cnt_q;
		rpm_d         = rpm_q;
		speed_d       = speed_q;
		load_d        = load_q;
		thr_d         = thr_q;
		err_d         = err_q;
		if (feed) begin
			unique case (phase_q)
				obdpid_pkg::PH_SEEK_RPM, obdpid_pkg::PH_SEEK_SPEED,
				obdpid_pkg::PH_SEEK_LOAD, obdpid_pkg::PH_SEEK_THR: begin
					if (id_match) begin
						prior_valid_d = 1'b0;
						cnt_d         = 2'd0;
					end else begin
						prior_d       = char_s1;
						prior_valid_d = 1'b1;
					end
				end
				obdpid_pkg::PH_RPM_DATA: begin
					pend_d = {pend_q[15:0], char_s1};
					cnt_d  = cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						if (pair_a.ok && pair_b.ok) begin
							rpm_d         = {pair_a.value, pair_b.value[7:2]};
							cnt_d         = 2'd0;
							prior_valid_d = 1'b0;
						end else begin
							err_d = obdpid_pkg::ST_RPM_BAD;
						end
					end
				end
				obdpid_pkg::PH_SPEED_DATA, obdpid_pkg::PH_LOAD_DATA,
				obdpid_pkg::PH_THR_DATA: begin
					pend_d = {pend_q[15:0], char_s1};
					cnt_d  = cnt_q + 2'd1;
					if (cnt_q == 2'd1) begin
						if (pair_b.ok) begin
							cnt_d         = 2'd0;
							prior_valid_d = 1'b0;
							if (phase_q == obdpid_pkg::PH_SPEED_DATA) begin
								speed_d = mph_prod[39:32];
							end else if (phase_q == obdpid_pkg::PH_LOAD_DATA) begin
								load_d = obdpid_pkg::scale_pct(pair_b.value);
							end else begin
								thr_d = obdpid_pkg::scale_pct(pair_b.value);
							end
						end else begin
							err_d = obdpid_pkg::end_status(phase_q);
						end
					end
				end
				default: err_d = err_q;
			endcase
		end
	end

	assign st_d = (phase_d == obdpid_pkg::PH_FAILED) ? err_d : obdpid_pkg::end_status(phase_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= obdpid_pkg::PH_SEEK_RPM;
			prior_q       <= 8'd0;
			prior_valid_q <= 1'b0;
			pend_q        <= 24'd0;
			cnt_q         <= 2'd0;
			rpm_q         <= 14'd0;
			speed_q       <= 8'd0;
			load_q        <= 7'd0;
			thr_q         <= 7'd0;
			err_q         <= obdpid_pkg::ST_OK;
		end else if (s1_go) begin
			if (last_s1) begin
				phase_q       <= obdpid_pkg::PH_SEEK_RPM;
				prior_q       <= 8'd0;
				prior_valid_q <= 1'b0;
				pend_q        <= 24'd0;
				cnt_q         <= 2'd0;
				rpm_q         <= 14'd0;
				speed_q       <= 8'd0;
				load_q        <= 7'd0;
				thr_q         <= 7'd0;
				err_q         <= obdpid_pkg::ST_OK;
			end else begin
				phase_q       <= phase_d;
				prior_q       <= prior_d;
				prior_valid_q <= prior_valid_d;
				pend_q        <= pend_d;
				cnt_q         <= cnt_d;
				rpm_q         <= rpm_d;
				speed_q       <= speed_d;
				load_q        <= load_d;
				thr_q         <= thr_d;
				err_q         <= err_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			status_out_q <= st_d;
			if (st_d == obdpid_pkg::ST_OK) begin
				rpm_out_q   <= rpm_d;
				speed_out_q <= speed_d;
				load_out_q  <= load_d;
				thr_out_q   <= thr_d;
			end else begin
				rpm_out_q   <= 14'd0;
				speed_out_q <= 8'd0;
				load_out_q  <= 7'd0;
				thr_out_q   <= 7'd0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign engine_rpm       = rpm_out_q;
	assign speed_mph        = speed_out_q;
	assign load_percent     = load_out_q;
	assign throttle_percent = thr_out_q;
	assign status           = status_out_q;

	assign chk_err   = out_valid && status != obdpid_pkg::ST_OK;
	assign chk_zero  = engine_rpm == 14'd0 && speed_mph == 8'd0 && load_percent == 7'd0
		&& throttle_percent == 7'd0;
	assign chk_range = speed_mph <= 8'd158 && load_percent <= 7'd100
		&& throttle_percent <= 7'd100 && status <= obdpid_pkg::ST_NO_THROTTLE;
	assign chk_fresh = phase_q == obdpid_pkg::PH_SEEK_RPM && !prior_valid_q && out_valid_q;

	`OBD_ASSERT_IMP(a_zero_on_error, chk_err, chk_zero, "values not zero on error status")
	`OBD_ASSERT_IMP(a_value_range, out_valid, chk_range, "result value out of range")
	`OBD_ASSERT_NEXT(a_restart, s1_go && last_s1, chk_fresh, "parser not restarted after last beat")

endmodule

`default_nettype wire
